### rtl/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Types, character codes and helper functions shared by the integer parser.
// ----------------------------------------------------------------------------
package sip_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int OFFSET_WIDTH = 16;

   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [OFFSET_WIDTH-1:0] offset_type;
   typedef logic [5:0]              base_type;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;

   localparam base_type BASE_AUTO = 6'd0;
   localparam base_type BASE_OCT  = 6'd8;
   localparam base_type BASE_DEC  = 6'd10;
   localparam base_type BASE_HEX  = 6'd16;

   localparam logic [7:0] LETTER_BIAS = 8'd10;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_LEAD  = 3'd1,
      PH_SIGN  = 3'd2,
      PH_ZERO  = 3'd3,
      PH_DIGIT = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] character;
      logic       string_start;
      base_type   radix;
   } req_type;

   typedef struct packed {
      logic signed [63:0] value;
      offset_type         end_offset;
      logic               digits_found;
   } rsp_type;

   typedef struct packed {
      logic     ok;
      base_type val;
   } digit_type;

   function automatic digit_type digit_of(input logic [7:0] c);
      digit_type  d;
      logic [7:0] t;
      d.ok = 1'b1;
      t    = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         t = c - CHAR_ZERO;
      end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         t = c - CHAR_LOW_A + LETTER_BIAS;
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         t = c - CHAR_UP_A + LETTER_BIAS;
      end else begin
         d.ok = 1'b0;
      end
      d.val = t[5:0];
      return d;
   endfunction

   function automatic count_type sat_inc(input count_type c);
      return (c == '1) ? c : c + count_type'(1);
   endfunction

   function automatic offset_type clip_offset(input count_type c);
      if ((c >> OFFSET_WIDTH) != '0) begin
         return '1;
      end
      return OFFSET_WIDTH'(c);
   endfunction

endpackage

### rtl/sip_in_stage.sv
// ----------------------------------------------------------------------------
// sip_in_stage
// Input register: holds one character beat until the parse step takes it.
// ----------------------------------------------------------------------------
module sip_in_stage (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  sip_pkg::req_type req_data,
   input  logic            advance,
   output logic            item_valid,
   output sip_pkg::req_type item
);

   logic            vld_ff;
   logic            vld_in;
   sip_pkg::req_type data_ff;
   logic            load;

   assign req_stall  = vld_ff & ~advance;
   assign load       = req_valid & ~req_stall;
   assign item_valid = vld_ff;
   assign item       = data_ff;

   always_comb begin
      if (load) begin
         vld_in = 1'b1;
      end else if (advance) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

endmodule

### rtl/sip_core.sv
// ----------------------------------------------------------------------------
// sip_core
// Parser state and the per-character step: blanks, sign, prefix, digits.
// ----------------------------------------------------------------------------
module sip_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  sip_pkg::req_type item,
   input  logic             out_free,
   output logic             advance,
   output logic             emit,
   output sip_pkg::rsp_type result
);

   sip_pkg::phase_type phase_ff, phase_in;
   logic [63:0]        acc_ff, acc_in;
   logic               neg_ff, neg_in;
   sip_pkg::base_type  base_ff, base_in;
   logic               any_ff, any_in;
   sip_pkg::count_type cnt_ff, cnt_in;

   // state as seen by this beat, after a string start has been applied
   sip_pkg::phase_type ph;
   logic [63:0]        acc;
   logic               neg;
   sip_pkg::base_type  base;
   logic               any;
   sip_pkg::count_type cnt;

   sip_pkg::digit_type dig;
   logic [7:0]         c;
   logic               body;
   logic               take;
   logic               stop;

   assign c   = item.character;
   assign dig = sip_pkg::digit_of(c);

   always_comb begin
      ph   = phase_ff;
      acc  = acc_ff;
      neg  = neg_ff;
      base = base_ff;
      any  = any_ff;
      cnt  = cnt_ff;
      if (item.string_start) begin
         ph   = sip_pkg::PH_LEAD;
         acc  = '0;
         neg  = 1'b0;
         base = item.radix;
         any  = 1'b0;
         cnt  = '0;
      end

      phase_in = ph;
      acc_in   = acc;
      neg_in   = neg;
      base_in  = base;
      any_in   = any;
      cnt_in   = cnt;
      body     = 1'b0;
      take     = 1'b0;
      stop     = 1'b0;

      unique case (ph)
         sip_pkg::PH_LEAD: begin
            if (c == sip_pkg::CHAR_SPACE || c == sip_pkg::CHAR_TAB) begin
               cnt_in = sip_pkg::sat_inc(cnt);
            end else if (c == sip_pkg::CHAR_PLUS || c == sip_pkg::CHAR_MINUS) begin
               neg_in   = (c == sip_pkg::CHAR_MINUS);
               cnt_in   = sip_pkg::sat_inc(cnt);
               phase_in = sip_pkg::PH_SIGN;
            end else begin
               body = 1'b1;
            end
         end
         sip_pkg::PH_SIGN: begin
            body = 1'b1;
         end
         sip_pkg::PH_ZERO: begin
            if (c == sip_pkg::CHAR_LOW_X || c == sip_pkg::CHAR_UP_X) begin
               base_in  = sip_pkg::BASE_HEX;
               cnt_in   = sip_pkg::sat_inc(cnt);
               phase_in = sip_pkg::PH_DIGIT;
            end else begin
               // the leading zero is itself a digit
               if (base == sip_pkg::BASE_AUTO) begin
                  base_in = sip_pkg::BASE_OCT;
               end
               acc_in   = '0;
               any_in   = 1'b1;
               phase_in = sip_pkg::PH_DIGIT;
               take     = 1'b1;
            end
         end
         sip_pkg::PH_DIGIT: begin
            take = 1'b1;
         end
         sip_pkg::PH_IDLE: begin
            phase_in = sip_pkg::PH_IDLE;
         end
         default: begin
            phase_in = sip_pkg::PH_IDLE;
         end
      endcase

      if (body) begin
         if (c == sip_pkg::CHAR_ZERO &&
             (base == sip_pkg::BASE_AUTO || base == sip_pkg::BASE_HEX)) begin
            phase_in = sip_pkg::PH_ZERO;
            cnt_in   = sip_pkg::sat_inc(cnt);
         end else begin
            if (base == sip_pkg::BASE_AUTO) begin
               base_in = sip_pkg::BASE_DEC;
            end
            phase_in = sip_pkg::PH_DIGIT;
            take     = 1'b1;
         end
      end

      if (take) begin
         if (!dig.ok || dig.val >= base_in) begin
            stop     = 1'b1;
            phase_in = sip_pkg::PH_IDLE;
         end else begin
            acc_in = 64'(acc_in * 64'(base_in)) + 64'(dig.val);
            any_in = 1'b1;
            cnt_in = sip_pkg::sat_inc(cnt);
         end
      end
   end

   assign emit    = item_valid & stop;
   assign advance = item_valid & (~stop | out_free);

   // acc is zero on the zero-prefix path, so no need to take acc_in here
   assign result.value        = neg ? 64'(-acc) : acc;
   assign result.end_offset   = any_in ? sip_pkg::clip_offset(cnt) : '0;
   assign result.digits_found = any_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sip_pkg::PH_IDLE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         base_ff  <= '0;
         any_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
         any_ff   <= any_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### rtl/sip_out_stage.sv
// ----------------------------------------------------------------------------
// sip_out_stage
// Result register: holds a finished result until the receiver takes the beat.
// ----------------------------------------------------------------------------
module sip_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  sip_pkg::rsp_type result,
   output logic             out_free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sip_pkg::rsp_type rsp_data
);

   logic             vld_ff;
   logic             vld_in;
   sip_pkg::rsp_type data_ff;

   assign out_free  = ~vld_ff | ~rsp_stall;
   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      if (load) begin
         vld_in = 1'b1;
      end else if (~rsp_stall) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

### rtl/string_to_int64_parser.sv
// ----------------------------------------------------------------------------
// string_to_int64_parser
// Streaming string to signed 64-bit integer parser, one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one character per beat, with string_start set on the first
//   character of a string and radix (0 = auto, 2..36) sampled on that beat.
//   rsp_ carries one result per number: value, end_offset, digits_found.
//   A beat moves when valid is high and stall is low.
// Throughput: one character per cycle while no held result is stalled.
//   The parse step (digit decode, one 64 x 6 multiply and an add) sits
//   between the input and result registers, so a character enters each cycle.
// Result path: a number's terminating character (any character that is not
//   a digit of the base, NUL included) passes the input register, and its
//   result is then loaded into the result register, which drives rsp_.
// Stall: a waiting result stays in the result register; characters that
//   do not end a number keep flowing. A character that ends a number while
//   the held result is still stalled waits in the input register.
// Reset: synchronous, active high; parser goes idle and ignores characters
//   until the next string start. Both registers are emptied.
// ----------------------------------------------------------------------------
module string_to_int64_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sip_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sip_pkg::rsp_type rsp_data
);

   logic             advance;
   logic             emit;
   logic             item_valid;
   logic             out_free;
   sip_pkg::req_type item;
   sip_pkg::rsp_type result;

   sip_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sip_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .advance    (advance),
      .emit       (emit),
      .result     (result)
   );

   sip_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (emit & advance),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a result with no digits reports zero value and zero offset
   a_nodigit_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.digits_found |->
         rsp_data.value == '0 && rsp_data.end_offset == '0)
      else $error("no-digit result carries non-zero fields");

   a_digit_offset : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.digits_found |-> rsp_data.end_offset != '0)
      else $error("digit result with zero end offset");

   a_emit_lands : assert property (@(posedge clock) disable iff (reset)
      emit && advance |=> rsp_valid)
      else $error("finished result not loaded into result register");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      emit && rsp_valid && rsp_stall |-> !advance)
      else $error("result overwrote a stalled beat");

endmodule

### tb/sv/parsed_number_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// parsed_number_scoreboard_pkg
// Tracks the parser state from the accepted characters and holds the numbers
// the parser owes, checking each result beat against the oldest one due.
// ----------------------------------------------------------------------------
package parsed_number_scoreboard_pkg;

   import sip_pkg::*;

   class parsed_number_scoreboard;

      phase_type   phase;
      logic [63:0] acc;
      logic        neg;
      base_type    base;
      logic        any_digit;
      count_type   count;

      rsp_type     numbers_due[$];

      int unsigned errors;
      int unsigned chars_seen;
      int unsigned starts_seen;
      int unsigned checked;
      int unsigned empty_numbers;
      int unsigned clipped;

      function new();
         phase         = PH_IDLE;
         acc           = '0;
         neg           = 1'b0;
         base          = BASE_AUTO;
         any_digit     = 1'b0;
         count         = '0;
         errors        = 0;
         chars_seen    = 0;
         starts_seen   = 0;
         checked       = 0;
         empty_numbers = 0;
         clipped       = 0;
      endfunction

      task report_mismatch(input string what);
         errors++;
         $display("[%0t] mismatch %0d: %s", $time, errors, what);
      endtask

      function int weight_of(input logic [7:0] c);
         if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
         if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) return int'(c - CHAR_LOW_A) + 10;
         if (c >= CHAR_UP_A && c <= CHAR_UP_Z) return int'(c - CHAR_UP_A) + 10;
         return -1;
      endfunction

      function void bump();
         if (count != '1) count = count + 1'b1;
      endfunction

      // digit phase: accumulate, or close the number and queue its result
      function void digit_step(input logic [7:0] c);
         rsp_type     num;
         int          d;
         logic [63:0] off;
         d = weight_of(c);
         if (d < 0 || d >= int'(base)) begin
            off              = any_digit ? 64'(count) : 64'd0;
            num.value        = neg ? -acc : acc;
            num.end_offset   = (off > 64'hFFFF) ? '1 : off[15:0];
            num.digits_found = any_digit;
            numbers_due.push_back(num);
            phase = PH_IDLE;
         end else begin
            acc       = acc * 64'(base) + 64'(d);
            any_digit = 1'b1;
            bump();
         end
      endfunction

      // first character after blanks and sign
      function void body_step(input logic [7:0] c);
         if (c == CHAR_ZERO && (base == BASE_AUTO || base == BASE_HEX)) begin
            phase = PH_ZERO;
            bump();
         end else begin
            if (base == BASE_AUTO) base = BASE_DEC;
            phase = PH_DIGIT;
            digit_step(c);
         end
      endfunction

      function void note_char(input req_type r);
         logic [7:0] c;
         c = r.character;
         chars_seen++;
         if (r.string_start) begin
            starts_seen++;
            phase     = PH_LEAD;
            acc       = '0;
            neg       = 1'b0;
            base      = r.radix;
            any_digit = 1'b0;
            count     = '0;
         end
         case (phase)
            PH_LEAD: begin
               if (c == CHAR_SPACE || c == CHAR_TAB) begin
                  bump();
               end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                  neg   = (c == CHAR_MINUS);
                  phase = PH_SIGN;
                  bump();
               end else begin
                  body_step(c);
               end
            end
            PH_SIGN: begin
               body_step(c);
            end
            PH_ZERO: begin
               if (c == CHAR_LOW_X || c == CHAR_UP_X) begin
                  base  = BASE_HEX;
                  phase = PH_DIGIT;
                  bump();
               end else begin
                  // the leading zero is itself a digit
                  if (base == BASE_AUTO) base = BASE_OCT;
                  acc       = '0;
                  any_digit = 1'b1;
                  phase     = PH_DIGIT;
                  digit_step(c);
               end
            end
            PH_DIGIT: begin
               digit_step(c);
            end
            default: begin
               phase = PH_IDLE;
            end
         endcase
      endfunction

      task check_number(input rsp_type got);
         rsp_type want;
         if (numbers_due.size() == 0) begin
            report_mismatch($sformatf("result with none due: value %h offset %0d digits %0b",
                                      got.value, got.end_offset, got.digits_found));
            return;
         end
         want = numbers_due.pop_front();
         checked++;
         if (!want.digits_found) empty_numbers++;
         if (want.end_offset == '1) clipped++;
         if (got.value !== want.value) begin
            report_mismatch($sformatf("value %h, want %h", got.value, want.value));
         end
         if (got.end_offset !== want.end_offset) begin
            report_mismatch($sformatf("end_offset %0d, want %0d",
                                      got.end_offset, want.end_offset));
         end
         if (got.digits_found !== want.digits_found) begin
            report_mismatch($sformatf("digits_found %b, want %b",
                                      got.digits_found, want.digits_found));
         end
      endtask

   endclass

endpackage

### tb/sv/tb_string_to_int64_parser.sv
// ----------------------------------------------------------------------------
// tb_string_to_int64_parser
// Streams strings through the parser one character per beat: a directed set
// of corner cases, one long run of digits with no gaps, then random strings
// with random gaps on both channels, a stretch with no gaps, and a long
// result hold-off that backs the parser up.
// ----------------------------------------------------------------------------
module tb_string_to_int64_parser;

   import sip_pkg::*;
   import parsed_number_scoreboard_pkg::*;

   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned LONG_RUN     = 40;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   logic    req_idling = 1'b0;
   logic    rsp_idling = 1'b0;
   logic    squeeze    = 1'b0;

   parsed_number_scoreboard board;

   string_to_int64_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         board.note_char(req_data);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_number(rsp_data);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("[%0t] no beat on either channel for %0d cycles", $time, QUIET_LIMIT);
      $display("string_to_int64_parser verification failed");
      $finish;
   end

   // result side: random stall, plus one long hold-off when asked
   initial begin : receiver
      logic held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= rsp_idling && ($urandom_range(99) < 34);
      end
   end

   function automatic logic [7:0] glyph(input int unsigned v);
      if (v < 10) return 8'(CHAR_ZERO + v);
      return 8'(($urandom_range(1) ? CHAR_LOW_A : CHAR_UP_A) + v - 10);
   endfunction

   task automatic send_char(input logic [7:0] c, input logic first, input base_type radix);
      base_type r;
      r = first ? radix : base_type'($urandom_range(63));
      while (req_idling && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{character: c, string_start: first, radix: r};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_text(input string s, input base_type radix);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == 0, radix);
      end
   endtask

   task automatic random_strings(input int unsigned goal);
      logic [7:0]  text[$];
      base_type    radix;
      int unsigned span;
      int unsigned sent;
      int unsigned cut;
      sent = 0;
      while (sent < goal) begin
         text.delete();
         if ($urandom_range(99) < 10) begin
            // noise: raw bytes with stray string starts
            repeat ($urandom_range(1, 8)) begin
               send_char(8'($urandom_range(255)), $urandom_range(3) == 0,
                         base_type'($urandom_range(63)));
               sent++;
            end
            continue;
         end
         case ($urandom_range(9))
            0, 1, 2: radix = BASE_AUTO;
            3:       radix = BASE_DEC;
            4:       radix = BASE_HEX;
            5:       radix = BASE_OCT;
            6:       radix = 6'd2;
            7:       radix = 6'd36;
            8:       radix = 6'd1;
            default: radix = base_type'($urandom_range(63));
         endcase
         span = (radix > 6'd36) ? 36 : ((radix == BASE_AUTO) ? 10 : int'(radix));
         repeat ($urandom_range(2)) text.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
         case ($urandom_range(2))
            1:       text.push_back(CHAR_PLUS);
            2:       text.push_back(CHAR_MINUS);
            default: ;
         endcase
         if (radix == BASE_AUTO || radix == BASE_HEX) begin
            case ($urandom_range(2))
               0: begin
                  text.push_back(CHAR_ZERO);
                  text.push_back($urandom_range(1) ? CHAR_LOW_X : CHAR_UP_X);
                  span = 16;
               end
               1: begin
                  if (radix == BASE_AUTO) begin
                     text.push_back(CHAR_ZERO);
                     span = 8;
                  end
               end
               default: begin
                  if (radix == BASE_AUTO) text.push_back(glyph($urandom_range(1, 9)));
               end
            endcase
         end
         // long runs of digits can push the value through wrap-around
         repeat (($urandom_range(99) < 15) ? $urandom_range(17, 24) : $urandom_range(0, 6))
            text.push_back(glyph($urandom_range(span - 1)));
         case ($urandom_range(3))
            0:       text.push_back(CHAR_NUL);
            1:       text.push_back(CHAR_SPACE);
            default: text.push_back(8'($urandom_range(255)));
         endcase
         cut = text.size();
         if ($urandom_range(99) < 8) cut = $urandom_range(1, text.size());
         for (int i = 0; i < cut; i++) begin
            send_char(text[i], i == 0, radix);
         end
         sent += cut;
         repeat (($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0)
            send_char(8'($urandom_range(255)), 1'b0, radix);
      end
   endtask

   initial begin : stimulus
      board = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // corner cases
      req_idling = 1'b1;
      rsp_idling <= 1'b1;
      send_char(CHAR_UP_A, 1'b0, BASE_AUTO);        // no string open: ignored
      send_text(" -12", BASE_DEC);
      send_char(CHAR_NUL, 1'b0, BASE_AUTO);
      send_text("\t0xg", BASE_AUTO);                // prefix with no hex digit
      send_text("017 ", BASE_AUTO);                 // octal by leading zero
      send_text("+0Xff", BASE_HEX);
      send_char(8'hFF, 1'b0, BASE_AUTO);
      send_text("012", 6'd1);                       // base one: only zero
      send_text("zZ9.", 6'd63);                     // base beyond 36
      send_text("7", BASE_DEC);                     // dropped by the next start
      send_text("-\t", 6'd36);                      // blank after the sign
      send_text("0", BASE_AUTO);
      send_char(CHAR_NUL, 1'b0, BASE_AUTO);

      // one long decimal string, back to back, wrapping the value
      req_idling = 1'b0;
      rsp_idling <= 1'b0;
      send_char(glyph($urandom_range(1, 9)), 1'b1, BASE_DEC);
      repeat (LONG_RUN) send_char(glyph($urandom_range(9)), 1'b0, BASE_DEC);
      send_char(CHAR_NUL, 1'b0, BASE_DEC);

      req_idling = 1'b1;
      rsp_idling <= 1'b1;
      random_strings(560);

      req_idling = 1'b0;
      rsp_idling <= 1'b0;
      random_strings(360);

      // receiver holds off while characters keep coming
      squeeze    <= 1'b1;
      rsp_idling <= 1'b1;
      random_strings(360);
      req_valid <= 1'b0;
      @(posedge clock);

      while (board.numbers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d characters over %0d string starts, %0d numbers checked",
               board.chars_seen, board.starts_seen, board.checked);
      $display("     (%0d with no digits, %0d with a clipped offset), %0d mismatches",
               board.empty_numbers, board.clipped, board.errors);
      if (board.errors == 0) begin
         $display("string_to_int64_parser verification clean");
      end else begin
         $display("string_to_int64_parser verification failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/sip_pkg.sv
rtl/sip_in_stage.sv
rtl/sip_core.sv
rtl/sip_out_stage.sv
rtl/string_to_int64_parser.sv
tb/sv/parsed_number_scoreboard_pkg.sv
tb/sv/tb_string_to_int64_parser.sv
